FILE: hw/rtl/rmbx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbx_pkg - shared types and constants of the ring mailbox
// Operation, status and register index codes, and the fixed field widths.
// ----------------------------------------------------------------------------
package rmbx_pkg;

	// fixed field widths
	localparam int unsigned ITEM_W     = 32;
	localparam int unsigned FILL_W     = 5;
	localparam int unsigned DROP_W     = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// capacity after reset
	localparam logic [FILL_W-1:0] CAP_RESET = 5'd16;

	// operation codes
	typedef enum logic [1:0] {
		OP_SEND  = 2'd0,
		OP_RECV  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_FLUSH = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_MODE = 2'd1;

endpackage

FILE: hw/rtl/rmbx_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbx_req_if - mailbox operation channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
interface rmbx_req_if
	import rmbx_pkg::*;
();
	logic              valid;
	logic              ready;
	op_t               op;
	logic [ITEM_W-1:0] item_data;

	modport source (output valid, output op, output item_data, input ready);
	modport sink (input valid, input op, input item_data, output ready);
endinterface

FILE: hw/rtl/rmbx_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbx_rsp_if - mailbox result channel
// Valid/ready channel carrying one result item per operation.
// ----------------------------------------------------------------------------
interface rmbx_rsp_if
	import rmbx_pkg::*;
();
	logic              valid;
	logic              ready;
	status_t           status;
	logic [ITEM_W-1:0] item_out;
	logic              overwrote;
	logic [FILL_W-1:0] fill_level;
	logic [DROP_W-1:0] drop_total;

	modport source (output valid, output status, output item_out, output overwrote,
		output fill_level, output drop_total, input ready);
	modport sink (input valid, input status, input item_out, input overwrote,
		input fill_level, input drop_total, output ready);
endinterface

FILE: hw/rtl/rmbx_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbx_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface rmbx_cfg_if
	import rmbx_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/ring_mailbox_with_overflow_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_mailbox_with_overflow_policy - circular mailbox with full policy
// Latency: the result of an item is valid the cycle after the item is taken.
// Throughput: one item per cycle while results are taken; the single result
// register holds req.ready low while its item waits on rsp.
// Reset clears pointers, fill count, drop counter and the output valid, and
// sets capacity 16 and reject mode; slot contents are not cleared.
// ----------------------------------------------------------------------------
module ring_mailbox_with_overflow_policy
	import rmbx_pkg::*;
#(
	parameter int unsigned DEPTH     = 16,
	parameter int unsigned ITEM_BITS = 32
) (
	input logic          clk,
	input logic          arst_n,
	rmbx_cfg_if.sink     cfg,
	rmbx_req_if.sink     req,
	rmbx_rsp_if.source   rsp
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// next pointer, wrapping at the effective capacity
	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
		input logic [FILL_W-1:0] cap);
		logic [31:0] nxt;
		nxt = 32'(p) + 32'd1;
		return (nxt >= 32'(cap)) ? '0 : PTR_W'(nxt);
	endfunction

	// configuration registers
	logic [FILL_W-1:0] capacity_q;
	logic              drop_mode_q;

	// mailbox state
	logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
	logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
	logic [FILL_W-1:0] count_q, count_d;
	logic [DROP_W-1:0] drops_q, drops_d;

	// slot memory
	logic [ITEM_BITS-1:0] slot_mem [DEPTH];
	logic [ITEM_BITS-1:0] wdata;
	logic [63:0]          data_ext;
	logic [63:0]          rdata_ext;

	// result stage
	logic                 valid_s1;
	status_t              status_s1;
	logic                 over_s1;
	logic                 pop_s1;
	logic [ITEM_BITS-1:0] rdata_s1;

	// operation decode
	logic              accept;
	logic [FILL_W-1:0] cap_eff;
	logic [DROP_W-1:0] drops_inc;
	status_t           status_d;
	logic              over_d;
	logic              pop_d;
	logic              wr_en;

	assign cfg.ready = 1'b1;
	assign req.ready = !valid_s1 || rsp.ready;
	assign accept    = req.valid && req.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			drop_mode_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_CAPACITY:  capacity_q  <= cfg.data[FILL_W-1:0];
				CFG_DROP_MODE: drop_mode_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// effective capacity clamped to 1..DEPTH
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = FILL_W'(1);
		end else if (32'(capacity_q) > DEPTH) begin
			cap_eff = FILL_W'(DEPTH);
		end else begin
			cap_eff = capacity_q;
		end
	end

	// saturating drop increment
	assign drops_inc = (drops_q == '1) ? drops_q : drops_q + DROP_W'(1);

	// next state of the mailbox for the operation at the input
	always_comb begin
		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		count_d  = count_q;
		drops_d  = drops_q;
		status_d = ST_OK;
		over_d   = 1'b0;
		pop_d    = 1'b0;
		wr_en    = 1'b0;
		case (req.op)
			OP_SEND: begin
				if (count_q >= cap_eff) begin
					drops_d = drops_inc;
					if (drop_mode_q) begin
						// discard oldest, store new, count unchanged
						rd_ptr_d = advance(rd_ptr_q, cap_eff);
						wr_ptr_d = advance(wr_ptr_q, cap_eff);
						over_d   = 1'b1;
						wr_en    = 1'b1;
					end else begin
						status_d = ST_FULL;
					end
				end else begin
					wr_ptr_d = advance(wr_ptr_q, cap_eff);
					count_d  = count_q + FILL_W'(1);
					wr_en    = 1'b1;
				end
			end
			OP_RECV: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					rd_ptr_d = advance(rd_ptr_q, cap_eff);
					count_d  = count_q - FILL_W'(1);
					pop_d    = 1'b1;
				end
			end
			OP_CLEAR: begin
				drops_d = '0;
			end
			default: begin
				rd_ptr_d = '0;
				wr_ptr_d = '0;
				count_d  = '0;
				drops_d  = '0;
			end
		endcase
	end

	// mailbox state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
			drops_q  <= '0;
		end else if (accept) begin
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
			count_q  <= count_d;
			drops_q  <= drops_d;
		end
	end

	// item word masked to the slot width
	assign data_ext = {32'd0, req.item_data};
	assign wdata    = data_ext[ITEM_BITS-1:0];

	// slot memory: write at tail, registered read of head
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			slot_mem[wr_ptr_q] <= wdata;
		end
		if (accept) begin
			rdata_s1 <= slot_mem[rd_ptr_q];
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			over_s1   <= over_d;
			pop_s1    <= pop_d;
		end
	end

	// popped item, zero unless a receive succeeded
	always_comb begin
		rdata_ext                = '0;
		rdata_ext[ITEM_BITS-1:0] = rdata_s1;
	end

	assign rsp.valid      = valid_s1;
	assign rsp.status     = status_s1;
	assign rsp.item_out   = pop_s1 ? rdata_ext[ITEM_W-1:0] : '0;
	assign rsp.overwrote  = over_s1;
	assign rsp.fill_level = count_q;
	assign rsp.drop_total = drops_q;

endmodule
